// ===== hdl/sorted_deadline_timer_queue_macros.svh =====
// ----------------------------------------------------------------------------
// sorted deadline timer queue: assertion macros
// shared property forms for the checks at the end of the top level
// ----------------------------------------------------------------------------
`ifndef SORTED_DEADLINE_TIMER_QUEUE_MACROS_SVH
`define SORTED_DEADLINE_TIMER_QUEUE_MACROS_SVH

// condition holds in the same cycle as the trigger
`define SDTQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition holds in the cycle after the trigger
`define SDTQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/sdtq_pkg.sv =====
// ----------------------------------------------------------------------------
// sdtq_pkg
// shared constants, command codes and controller/datapath interface types
// ----------------------------------------------------------------------------
`default_nettype none

package sdtq_pkg;

    // default sizing
    localparam int SLOTS_DEF      = 16;
    localparam int TICK_WIDTH_DEF = 32;

    // fixed field widths
    localparam int ID_W    = 4;
    localparam int DELAY_W = 32;

    // input command codes
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_ARM  = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic rem_rd;
        logic rem_ev;
        logic ins_rd;
        logic ins_ev;
        logic publish;
    } sdtq_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic in_tick;
        logic cnt_zero;
        logic is_tick;
        logic rem_done;
        logic reject;
        logic idx_zero;
        logic ins_shift;
    } sdtq_stat_t;

endpackage

`default_nettype wire

// ===== hdl/sorted_deadline_timer_queue.sv =====
// sequencing: on an empty queue a tick goes straight to the result and an arm straight to
//   the insertion walk; else the removal scan comes first, then the walk for an arm that
//   is not rejected; the result then waits until the output slot is free
// one item at a time: the entry memory has a single write port and a registered read
// reset: asynchronous, clears the tick count, the fill level, the sequencer and
//   the output valid; entry storage is not cleared, only filled slots are ever read
// ----------------------------------------------------------------------------
// sorted_deadline_timer_queue
// tick counter with a deadline-ordered queue of pending timers
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_deadline_timer_queue_macros.svh"

module sorted_deadline_timer_queue
    import sdtq_pkg::*;
#(
    parameter int SLOTS      = SLOTS_DEF,
    parameter int TICK_WIDTH = TICK_WIDTH_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               cmd,
    input  wire logic [ID_W-1:0]    timer_id,
    input  wire logic [DELAY_W-1:0] delay,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    fired,
    output logic [ID_W-1:0]         fired_id,
    output logic                    rejected
);

    sdtq_cmd_t  ctl;
    sdtq_stat_t sts;

    // sequencer
    sdtq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    // counter, entry memory and compare logic
    sdtq_dp #(
        .SLOTS      (SLOTS),
        .TICK_WIDTH (TICK_WIDTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .timer_id (timer_id),
        .delay    (delay),
        .ctl      (ctl),
        .sts      (sts),
        .fired    (fired),
        .fired_id (fired_id),
        .rejected (rejected)
    );

    // checks
    `SDTQ_ASSERT_SAME(a_fire_xor_reject, clk, rst_n, out_valid, !(fired && rejected), "fired and rejected together")
    `SDTQ_ASSERT_SAME(a_idle_id_zero, clk, rst_n, out_valid && !fired, fired_id == '0, "fired_id set without fire")
    `SDTQ_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_valid && in_ready, !in_ready, "ready held after transfer")
    `SDTQ_ASSERT_NEXT(a_publish_valid, clk, rst_n, ctl.publish, out_valid, "result published without valid")

endmodule

`default_nettype wire

// ===== hdl/sdtq_ctrl.sv =====
// ----------------------------------------------------------------------------
// sdtq_ctrl
// sequencer for the timer queue: removal scan, sorted insertion, result hand-off
// ----------------------------------------------------------------------------
`default_nettype none

module sdtq_ctrl
    import sdtq_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  wire logic       out_ready,
    input  wire sdtq_stat_t sts,
    output sdtq_cmd_t       ctl
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_REM_RD = 6'b000010,
        S_REM_EV = 6'b000100,
        S_INS_RD = 6'b001000,
        S_INS_EV = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // next state and command decode
    always_comb
    begin
        state_next     = state_reg;
        ctl            = '0;
        out_valid_next = out_valid_reg & ~out_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.load = 1'b1;
                    if (sts.cnt_zero)
                        state_next = sts.in_tick ? S_DONE : S_INS_RD;
                    else
                        state_next = S_REM_RD;
                end
            end
            S_REM_RD:
            begin
                ctl.rem_rd = 1'b1;
                state_next = S_REM_EV;
            end
            S_REM_EV:
            begin
                ctl.rem_ev = 1'b1;
                if (sts.rem_done)
                    state_next = (sts.is_tick || sts.reject) ? S_DONE : S_INS_RD;
                else
                    state_next = S_REM_RD;
            end
            S_INS_RD:
            begin
                ctl.ins_rd = 1'b1;
                state_next = sts.idx_zero ? S_DONE : S_INS_EV;
            end
            S_INS_EV:
            begin
                ctl.ins_ev = 1'b1;
                state_next = sts.ins_shift ? S_INS_RD : S_DONE;
            end
            S_DONE:
            begin
                // hand the result over once the output slot is free
                if (!out_valid_reg || out_ready)
                begin
                    ctl.publish    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and output valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== hdl/sdtq_dp.sv =====
// ----------------------------------------------------------------------------
// sdtq_dp
// tick counter, sorted entry memory and the compare/shift datapath
// ----------------------------------------------------------------------------
`default_nettype none

module sdtq_dp
    import sdtq_pkg::*;
#(
    parameter int SLOTS      = SLOTS_DEF,
    parameter int TICK_WIDTH = TICK_WIDTH_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd,
    input  wire logic [ID_W-1:0]    timer_id,
    input  wire logic [DELAY_W-1:0] delay,
    input  wire sdtq_cmd_t          ctl,
    output sdtq_stat_t              sts,
    output logic                    fired,
    output logic [ID_W-1:0]         fired_id,
    output logic                    rejected
);

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    // entry memory, single write port, registered read
    logic [TICK_WIDTH-1:0] mem_dl [SLOTS];
    logic [ID_W-1:0]       mem_id [SLOTS];
    logic [TICK_WIDTH-1:0] rd_dl_reg;
    logic [ID_W-1:0]       rd_id_reg;

    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [TICK_WIDTH-1:0] wr_dl;
    logic [ID_W-1:0]       wr_id;

    // control state
    logic [TICK_WIDTH-1:0] now_reg, now_next;
    logic [CW-1:0]         cnt_reg, cnt_next;

    // working registers for the current item
    logic [CW-1:0]         idx_reg, idx_next;
    logic                  hit_reg, hit_next;
    logic                  is_tick_reg, is_tick_next;
    logic [ID_W-1:0]       id_reg, id_next;
    logic [TICK_WIDTH-1:0] when_reg, when_next;
    logic                  res_fired_reg, res_fired_next;
    logic [ID_W-1:0]       res_id_reg, res_id_next;
    logic                  res_rej_reg, res_rej_next;

    // output payload
    logic                  fired_reg, fired_next;
    logic [ID_W-1:0]       fired_id_reg, fired_id_next;
    logic                  rejected_reg, rejected_next;

    logic [CW-1:0]         idx_inc;
    logic [CW-1:0]         idx_dec;
    logic                  idx_zero;
    logic                  match;
    logic                  hit_now;
    logic                  full;
    logic                  rem_done;
    logic                  reject;
    logic                  ins_shift;

    // compare and scan status
    always_comb
    begin
        idx_inc   = idx_reg + CW'(1);
        idx_dec   = idx_reg - CW'(1);
        idx_zero  = (idx_reg == '0);
        if (is_tick_reg)
            match = idx_zero && (rd_dl_reg <= now_reg);
        else
            match = (rd_id_reg == id_reg);
        hit_now   = hit_reg | match;
        full      = (cnt_reg == CW'(SLOTS));
        rem_done  = (idx_inc == cnt_reg) | (is_tick_reg & ~hit_now);
        reject    = ~is_tick_reg & ~hit_now & full;
        ins_shift = (rd_dl_reg >= when_reg);
    end

    // memory port selection
    always_comb
    begin
        rd_en   = ctl.rem_rd | (ctl.ins_rd & ~idx_zero);
        rd_addr = ctl.rem_rd ? idx_reg[AW-1:0] : idx_dec[AW-1:0];
        wr_en   = 1'b0;
        wr_addr = idx_reg[AW-1:0];
        wr_dl   = when_reg;
        wr_id   = id_reg;
        // close the gap left by the removed entry
        if (ctl.rem_ev && hit_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = idx_dec[AW-1:0];
            wr_dl   = rd_dl_reg;
            wr_id   = rd_id_reg;
        end
        // new entry at the head of the queue
        if (ctl.ins_rd && idx_zero)
        begin
            wr_en = 1'b1;
        end
        // move a later entry up, or drop the new one into its place
        if (ctl.ins_ev)
        begin
            wr_en = 1'b1;
            if (ins_shift)
            begin
                wr_dl = rd_dl_reg;
                wr_id = rd_id_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_dl[wr_addr] <= wr_dl;
            mem_id[wr_addr] <= wr_id;
        end
        if (rd_en)
        begin
            rd_dl_reg <= mem_dl[rd_addr];
            rd_id_reg <= mem_id[rd_addr];
        end
    end

    // next values of the working and state registers
    always_comb
    begin
        now_next       = now_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        hit_next       = hit_reg;
        is_tick_next   = is_tick_reg;
        id_next        = id_reg;
        when_next      = when_reg;
        res_fired_next = res_fired_reg;
        res_id_next    = res_id_reg;
        res_rej_next   = res_rej_reg;
        fired_next     = fired_reg;
        fired_id_next  = fired_id_reg;
        rejected_next  = rejected_reg;

        // take the item in: tick advances time, arm computes the deadline
        if (ctl.load)
        begin
            is_tick_next   = (cmd == CMD_TICK);
            id_next        = timer_id;
            when_next      = now_reg + TICK_WIDTH'(delay);
            idx_next       = '0;
            hit_next       = 1'b0;
            res_fired_next = 1'b0;
            res_id_next    = '0;
            res_rej_next   = 1'b0;
            if (cmd == CMD_TICK)
                now_next = now_reg + TICK_WIDTH'(1);
        end

        // removal scan: expired head on a tick, matching id on an arm
        if (ctl.rem_ev)
        begin
            hit_next = hit_now;
            if (is_tick_reg && match)
            begin
                res_fired_next = 1'b1;
                res_id_next    = rd_id_reg;
            end
            if (rem_done)
            begin
                cnt_next     = cnt_reg - CW'(hit_now);
                idx_next     = cnt_reg - CW'(hit_now);
                res_rej_next = reject;
            end
            else
            begin
                idx_next = idx_inc;
            end
        end

        // insertion walk from the tail downwards
        if (ctl.ins_rd && idx_zero)
            cnt_next = cnt_reg + CW'(1);
        if (ctl.ins_ev)
        begin
            if (ins_shift)
                idx_next = idx_dec;
            else
                cnt_next = cnt_reg + CW'(1);
        end

        // result transfer into the output register
        if (ctl.publish)
        begin
            fired_next    = res_fired_reg;
            fired_id_next = res_id_reg;
            rejected_next = res_rej_reg;
        end
    end

    // tick count and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            now_reg <= now_next;
            cnt_reg <= cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        hit_reg       <= hit_next;
        is_tick_reg   <= is_tick_next;
        id_reg        <= id_next;
        when_reg      <= when_next;
        res_fired_reg <= res_fired_next;
        res_id_reg    <= res_id_next;
        res_rej_reg   <= res_rej_next;
        fired_reg     <= fired_next;
        fired_id_reg  <= fired_id_next;
        rejected_reg  <= rejected_next;
    end

    // status to the controller
    always_comb
    begin
        sts.in_tick   = (cmd == CMD_TICK);
        sts.cnt_zero  = (cnt_reg == '0);
        sts.is_tick   = is_tick_reg;
        sts.rem_done  = rem_done;
        sts.reject    = reject;
        sts.idx_zero  = idx_zero;
        sts.ins_shift = ins_shift;
    end

    assign fired    = fired_reg;
    assign fired_id = fired_id_reg;
    assign rejected = rejected_reg;

endmodule

`default_nettype wire

// ===== tb/sv/timer_queue_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// timer_queue_checker
// watches both channels of the timer queue, keeps its own deadline-ordered
// copy of the pending timers and compares every result transfer with the
// outcome expected for the oldest outstanding request
// ----------------------------------------------------------------------------

module timer_queue_checker
    import sdtq_pkg::*;
#(
    parameter int SLOTS      = SLOTS_DEF,
    parameter int TICK_WIDTH = TICK_WIDTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic               cmd,
    input  logic [ID_W-1:0]    timer_id,
    input  logic [DELAY_W-1:0] delay,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic               fired,
    input  logic [ID_W-1:0]    fired_id,
    input  logic               rejected,
    output int                 mismatch_count,
    output int                 outcomes_awaited
);

    typedef struct packed {
        logic            fired;
        logic [ID_W-1:0] fired_id;
        logic            rejected;
    } timer_outcome_t;

    // shadow of the block state
    logic [TICK_WIDTH-1:0] tick_now;
    logic [TICK_WIDTH-1:0] slot_due [SLOTS];
    logic [ID_W-1:0]       slot_owner [SLOTS];
    int unsigned           slot_fill;

    timer_outcome_t        pending_outcomes [$];
    int                    outcome_index;

    task automatic note_mismatch(input string msg);
        mismatch_count = mismatch_count + 1;
        $display("ERROR %0t: result %0d: %s", $time, outcome_index, msg);
    endtask

    // close the gap left by the entry at pos
    function automatic void drop_entry(int unsigned pos);
        for (int unsigned k = pos; k + 1 < slot_fill; k++)
        begin
            slot_due[k]   = slot_due[k + 1];
            slot_owner[k] = slot_owner[k + 1];
        end
        if (slot_fill > 0)
            slot_fill = slot_fill - 1;
    endfunction

    // new entry goes ahead of the first one due at the same time or later
    function automatic void insert_by_deadline(logic [ID_W-1:0] id,
                                               logic [TICK_WIDTH-1:0] when);
        int unsigned pos;
        pos = 0;
        while (pos < slot_fill && slot_due[pos] < when)
            pos++;
        for (int unsigned k = slot_fill; k > pos; k--)
        begin
            slot_due[k]   = slot_due[k - 1];
            slot_owner[k] = slot_owner[k - 1];
        end
        slot_due[pos]   = when;
        slot_owner[pos] = id;
        slot_fill       = slot_fill + 1;
    endfunction

    function automatic timer_outcome_t predict_timer_outcome(logic c,
                                                             logic [ID_W-1:0] id,
                                                             logic [DELAY_W-1:0] d);
        timer_outcome_t        res;
        logic [63:0]           sum;
        logic [TICK_WIDTH-1:0] when;
        bit                    found;
        res   = '0;
        found = 1'b0;
        if (c == CMD_TICK)
        begin
            // count first, then at most one expiry from the head
            tick_now = tick_now + 1'b1;
            if (slot_fill > 0 && slot_due[0] <= tick_now)
            begin
                res.fired    = 1'b1;
                res.fired_id = slot_owner[0];
                drop_entry(0);
            end
        end
        else
        begin
            // deadline wraps at the tick width
            sum  = 64'(tick_now) + 64'(d);
            when = sum[TICK_WIDTH-1:0];
            for (int unsigned k = 0; k < slot_fill && !found; k++)
            begin
                if (slot_owner[k] == id)
                begin
                    drop_entry(k);
                    found = 1'b1;
                end
            end
            if (!found && slot_fill >= SLOTS)
                res.rejected = 1'b1;
            else
                insert_by_deadline(id, when);
        end
        return res;
    endfunction

    // result transfer checked before the request transfer of the same edge
    always @(posedge clk)
    begin : watch_channels
        timer_outcome_t seen;
        timer_outcome_t want;
        if (!rst_n)
        begin
            tick_now         = '0;
            slot_fill        = 0;
            mismatch_count   = 0;
            outcome_index    = 0;
            outcomes_awaited = 0;
            pending_outcomes.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                seen = {fired, fired_id, rejected};
                if (pending_outcomes.size() == 0)
                begin
                    note_mismatch($sformatf("unexpected: fired=%0b id=%0d rejected=%0b",
                                            seen.fired, seen.fired_id, seen.rejected));
                end
                else
                begin
                    want = pending_outcomes.pop_front();
                    if (seen.fired !== want.fired)
                        note_mismatch($sformatf("fired %0b, expected %0b",
                                                seen.fired, want.fired));
                    if (seen.fired_id !== want.fired_id)
                        note_mismatch($sformatf("fired_id %0d, expected %0d",
                                                seen.fired_id, want.fired_id));
                    if (seen.rejected !== want.rejected)
                        note_mismatch($sformatf("rejected %0b, expected %0b",
                                                seen.rejected, want.rejected));
                end
                outcome_index = outcome_index + 1;
            end
            if (in_valid && in_ready)
                pending_outcomes.push_back(predict_timer_outcome(cmd, timer_id, delay));
            outcomes_awaited = pending_outcomes.size();
        end
    end

endmodule

// ===== tb/sv/tb_sorted_deadline_timer_queue.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_deadline_timer_queue
// drives tick and arm requests into the timer queue with random gaps on both
// channels; a directed opening covers expiry order, wrap and re-arm on a full
// queue, then random traffic runs in three idling phases
// ----------------------------------------------------------------------------

module tb_sorted_deadline_timer_queue
    import sdtq_pkg::*;
();

    localparam int PHASE_ITEMS = 530;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic               cmd;
    logic [ID_W-1:0]    timer_id;
    logic [DELAY_W-1:0] delay;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               fired;
    logic [ID_W-1:0]    fired_id;
    logic               rejected;

    int                 mismatch_count;
    int                 outcomes_awaited;
    int                 send_idle_pct = 0;
    int                 take_idle_pct = 0;

    sorted_deadline_timer_queue DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .timer_id  (timer_id),
        .delay     (delay),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .fired     (fired),
        .fired_id  (fired_id),
        .rejected  (rejected)
    );

    timer_queue_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .cmd              (cmd),
        .timer_id         (timer_id),
        .delay            (delay),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .fired            (fired),
        .fired_id         (fired_id),
        .rejected         (rejected),
        .mismatch_count   (mismatch_count),
        .outcomes_awaited (outcomes_awaited)
    );

    // 2 ns clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // hard stop in case the block hangs
    initial
    begin
        #2000000;
        $display("tb_sorted_deadline_timer_queue: done, errors");
        $finish;
    end

    // receiver back-pressure
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= take_idle_pct);

    // one request transfer, with an optional random gap ahead of it
    task automatic send_item(input logic c, input logic [ID_W-1:0] id,
                             input logic [DELAY_W-1:0] d);
        @(negedge clk);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        timer_id <= id;
        delay    <= d;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // hold off requests until every outstanding result has come back
    task automatic wait_for_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (outcomes_awaited != 0)
            @(negedge clk);
    endtask

    initial
    begin : stimulus
        rst_n    = 1'b0;
        in_valid = 1'b0;
        cmd      = CMD_TICK;
        timer_id = '0;
        delay    = '0;
        send_idle_pct = 26;
        take_idle_pct = 46;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // tick on an empty queue, zero delay fires on the next tick
        send_item(CMD_TICK, 4'd0, 32'd0);
        send_item(CMD_ARM, 4'd0, 32'd0);
        send_item(CMD_TICK, 4'd0, 32'd0);
        // deadline wraps below the count and expires straight away
        send_item(CMD_ARM, 4'd15, 32'hFFFF_FFFF);
        send_item(CMD_TICK, 4'd0, 32'd0);
        // equal deadlines, newer first; then re-arm of a pending timer
        send_item(CMD_ARM, 4'd5, 32'd3);
        send_item(CMD_ARM, 4'd6, 32'd3);
        send_item(CMD_ARM, 4'd5, 32'd1);
        repeat (3) send_item(CMD_TICK, 4'hF, 32'hFFFF_FFFF);
        // fill every slot, then re-arm while full
        for (int i = 0; i < 16; i++)
            send_item(CMD_ARM, ID_W'(i), DELAY_W'(10 + i));
        send_item(CMD_ARM, 4'd7, 32'd0);

        // random traffic in three idling phases
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 26 : (phase == 1) ? 46 : 0;
            take_idle_pct = (phase == 0) ? 46 : (phase == 1) ? 26 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin : one_item
                int unsigned        roll;
                logic [DELAY_W-1:0] span;
                roll = $urandom_range(99);
                if (roll < 55)
                begin
                    send_item(CMD_TICK, ID_W'($urandom), DELAY_W'($urandom));
                end
                else
                begin
                    // mostly short delays so that timers actually expire
                    roll = $urandom_range(99);
                    if (roll < 60)
                        span = $urandom_range(20);
                    else if (roll < 75)
                        span = $urandom_range(255);
                    else if (roll < 88)
                        span = $urandom;
                    else
                        span = 32'hFFFF_FFFF - $urandom_range(15);
                    send_item(CMD_ARM, ID_W'($urandom), span);
                end
            end
            wait_for_drain();
        end

        // allow the slowest arm to settle
        repeat (100) @(negedge clk);
        if (mismatch_count == 0)
            $display("tb_sorted_deadline_timer_queue: done, clean");
        else
            $display("tb_sorted_deadline_timer_queue: done, errors");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/sdtq_pkg.sv
hdl/sdtq_ctrl.sv
hdl/sdtq_dp.sv
hdl/sorted_deadline_timer_queue.sv
tb/sv/timer_queue_checker.sv
tb/sv/tb_sorted_deadline_timer_queue.sv
